// ----- rtl/rppd_pkg.sv -----
package rppd_pkg;

   localparam int DEF_MAX_WIDTH = 4096;
   localparam int BYTE_W = 8;
   localparam int CH_NUM = 4;
   localparam int PIX_W = CH_NUM * BYTE_W;
   localparam int WIDTH_REG_W = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 13'd1;
   localparam logic FORMAT_RESET = 1'b1;

   typedef enum logic [1:0] {
      PRED_LEFT = 2'd0,
      PRED_ABOVE = 2'd1,
      PRED_AVERAGE = 2'd2
   } pred_type;

   typedef logic [CH_NUM-1:0][BYTE_W-1:0] pix_type;

   typedef struct packed {
      pred_type pred;
      logic col_zero;
      logic four_ch;
   } recon_ctrl_type;

endpackage

// ----- rtl/row_predictive_pixel_decoder_unit.sv -----
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | frame_start, row_flag, resid0..resid3
// rsp     | out       | rsp_valid / rsp_ready  | pixel0..pixel3, row_end
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One word per cycle is accepted while the result side keeps up.
// A word moves from the read stage, where the accepting edge starts the line buffer
// read, into the output register that holds the reconstructed pixel.
// The line buffer holds one pixel per column; a word in the same column as the word
// ahead of it takes the above pixel from the left pixel register.
// Reset clears control state and the left pixel register; the line buffer is not cleared and needs no sweep.
// A stalled result holds one word in the read stage, then req_ready drops.
module row_predictive_pixel_decoder_unit #(
   parameter int MAX_WIDTH = rppd_pkg::DEF_MAX_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_frame_start,
   input  logic [7:0] req_row_flag,
   input  logic [7:0] req_resid0,
   input  logic [7:0] req_resid1,
   input  logic [7:0] req_resid2,
   input  logic [7:0] req_resid3,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_pixel0,
   output logic [7:0] rsp_pixel1,
   output logic [7:0] rsp_pixel2,
   output logic [7:0] rsp_pixel3,
   output logic rsp_row_end,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rppd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rppd_pkg::WIDTH_REG_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WCMP = (CW + 1 > rppd_pkg::WIDTH_REG_W) ? CW + 1 : rppd_pkg::WIDTH_REG_W;

   logic [rppd_pkg::WIDTH_REG_W-1:0] width_ff;
   logic format_ff;
   logic [WCMP-1:0] width_ext;
   logic [CW-1:0] last_col;

   logic req_fire;
   logic [CW-1:0] base_col;
   logic [CW-1:0] acc_col;
   logic acc_first;
   logic acc_last;
   rppd_pkg::pred_type acc_pred;

   logic [CW-1:0] col_ff, col_in;
   logic first_row_ff, first_row_in;
   rppd_pkg::pred_type pred_ff, pred_in;

   logic s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_col_ff;
   rppd_pkg::pix_type s1_resid_ff;
   logic s1_first_ff;
   logic s1_last_ff;
   rppd_pkg::pred_type s1_pred_ff;
   logic s1_format_ff;
   logic s1_fwd_ff;
   logic s1_adv;

   rppd_pkg::pix_type rd_data;
   rppd_pkg::pix_type above;
   rppd_pkg::pix_type result;
   rppd_pkg::recon_ctrl_type ctrl;

   rppd_pkg::pix_type left_ff;
   logic out_valid_ff, out_valid_in;
   rppd_pkg::pix_type out_pix_ff;
   logic out_end_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rppd_pkg::WIDTH_RESET;
         format_ff <= rppd_pkg::FORMAT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rppd_pkg::CSR_IMAGE_WIDTH: width_ff <= csr_wdata;
            rppd_pkg::CSR_PIXEL_FORMAT: format_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A width of zero acts as one, and widths past the line buffer are clamped.
   assign width_ext = WCMP'(width_ff);

   always_comb begin
      if (width_ext == '0) begin
         last_col = '0;
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         last_col = CW'(MAX_WIDTH - 1);
      end else begin
         last_col = CW'(width_ext - WCMP'(1));
      end
   end

   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire = req_valid && req_ready;

   assign base_col = req_frame_start ? '0 : col_ff;
   assign acc_col = (base_col > last_col) ? last_col : base_col;
   assign acc_first = req_frame_start || first_row_ff;
   assign acc_last = (acc_col == last_col);

   always_comb begin
      if (acc_col != '0) begin
         acc_pred = pred_ff;
      end else if (req_row_flag[0]) begin
         acc_pred = rppd_pkg::PRED_LEFT;
      end else if (req_row_flag[1]) begin
         acc_pred = rppd_pkg::PRED_ABOVE;
      end else begin
         acc_pred = rppd_pkg::PRED_AVERAGE;
      end
   end

   always_comb begin
      col_in = col_ff;
      first_row_in = first_row_ff;
      pred_in = pred_ff;
      if (req_fire) begin
         col_in = acc_last ? '0 : acc_col + CW'(1);
         first_row_in = acc_last ? 1'b0 : acc_first;
         pred_in = acc_pred;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         first_row_ff <= 1'b1;
         pred_ff <= rppd_pkg::PRED_LEFT;
      end else begin
         col_ff <= col_in;
         first_row_ff <= first_row_in;
         pred_ff <= pred_in;
      end
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // The word ahead writes its column at the same edge as this read, so a match
   // must take that word's result instead of the stale buffer entry.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff <= acc_col;
         s1_resid_ff <= {req_resid3, req_resid2, req_resid1, req_resid0};
         s1_first_ff <= acc_first;
         s1_last_ff <= acc_last;
         s1_pred_ff <= acc_pred;
         s1_format_ff <= format_ff;
         s1_fwd_ff <= s1_adv && (s1_col_ff == acc_col);
      end
   end

   rppd_line_buf #(
      .DEPTH(MAX_WIDTH),
      .AW(CW)
   ) u_line_buf (
      .clock(clock),
      .rd_en(req_fire),
      .rd_addr(acc_col),
      .rd_data(rd_data),
      .wr_en(s1_adv),
      .wr_addr(s1_col_ff),
      .wr_data(result)
   );

   always_comb begin
      if (s1_first_ff) begin
         above = '0;
      end else if (s1_fwd_ff) begin
         above = left_ff;
      end else begin
         above = rd_data;
      end
   end

   assign ctrl.pred = s1_pred_ff;
   assign ctrl.col_zero = (s1_col_ff == '0);
   assign ctrl.four_ch = s1_format_ff;

   rppd_recon u_recon (
      .ctrl(ctrl),
      .resid(s1_resid_ff),
      .above(above),
      .left(left_ff),
      .pixel(result)
   );

   assign out_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            left_ff <= result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_pix_ff <= result;
         out_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel0 = out_pix_ff[0];
   assign rsp_pixel1 = out_pix_ff[1];
   assign rsp_pixel2 = out_pix_ff[2];
   assign rsp_pixel3 = out_pix_ff[3];
   assign rsp_row_end = out_end_ff;

endmodule

// ----- rtl/rppd_line_buf.sv -----
module rppd_line_buf #(
   parameter int DEPTH = rppd_pkg::DEF_MAX_WIDTH,
   parameter int AW = $clog2(rppd_pkg::DEF_MAX_WIDTH)
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [AW-1:0] rd_addr,
   output rppd_pkg::pix_type rd_data,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rppd_pkg::pix_type wr_data
);

   rppd_pkg::pix_type mem [DEPTH];
   rppd_pkg::pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rppd_recon.sv -----
module rppd_recon (
   input  rppd_pkg::recon_ctrl_type ctrl,
   input  rppd_pkg::pix_type resid,
   input  rppd_pkg::pix_type above,
   input  rppd_pkg::pix_type left,
   output rppd_pkg::pix_type pixel
);

   logic [rppd_pkg::CH_NUM-1:0][rppd_pkg::BYTE_W:0] sum;
   rppd_pkg::pix_type avg;
   rppd_pkg::pix_type value;

   always_comb begin
      for (int ch = 0; ch < rppd_pkg::CH_NUM; ch++) begin
         sum[ch] = {1'b0, above[ch]} + {1'b0, left[ch]};
         avg[ch] = sum[ch][rppd_pkg::BYTE_W:1];
         unique case (ctrl.pred)
            rppd_pkg::PRED_ABOVE: begin
               value[ch] = above[ch] - resid[ch];
            end
            rppd_pkg::PRED_LEFT: begin
               value[ch] = ctrl.col_zero ? resid[ch] : left[ch] - resid[ch];
            end
            rppd_pkg::PRED_AVERAGE: begin
               value[ch] = ctrl.col_zero ? resid[ch] : avg[ch] - resid[ch];
            end
            default: begin
               value[ch] = resid[ch];
            end
         endcase
      end
   end

   // Channel 3 is stored and shown as zero for three-channel pixels.
   always_comb begin
      pixel = value;
      if (!ctrl.four_ch) begin
         pixel[rppd_pkg::CH_NUM-1] = '0;
      end
   end

endmodule

// ----- rtl/rppd_checker.sv -----
module rppd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_frame_start,
   input logic [7:0] req_row_flag,
   input logic [7:0] req_resid0,
   input logic [7:0] req_resid1,
   input logic [7:0] req_resid2,
   input logic [7:0] req_resid3,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_pixel0,
   input logic [7:0] rsp_pixel1,
   input logic [7:0] rsp_pixel2,
   input logic [7:0] rsp_pixel3,
   input logic rsp_row_end,
   input logic csr_valid,
   input logic csr_ready,
   input logic [rppd_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [rppd_pkg::WIDTH_REG_W-1:0] csr_wdata
);

   // After reset both pipeline stages are empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

   // Input is only held off while a finished word waits at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // A result appearing at an empty output comes from a word that passed straight through the read stage.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching accepted word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel0) && $stable(rsp_pixel1)
         && $stable(rsp_pixel2) && $stable(rsp_pixel3) && $stable(rsp_row_end))
      else $error("stalled result changed");

endmodule

bind row_predictive_pixel_decoder_unit rppd_checker u_rppd_checker (.*);
